[design/sdtq_pkg.sv]
// Package for the sorted deadline timer queue: sizes, opcodes and beat types.
// No dependencies.
`timescale 1ns / 1ps
package sdtq_pkg;
  localparam int NumTimers = 32;
  localparam int IdxW = 6;
  localparam logic [IdxW-1:0] SentIdx = IdxW'(NumTimers);
  localparam logic [IdxW-1:0] NoLink = '1;
  localparam logic [31:0] SentDeadline = 32'hffffffff;
  localparam int MaxOut = 32;

  localparam logic [2:0] OpTick = 3'd0;
  localparam logic [2:0] OpAlloc = 3'd1;
  localparam logic [2:0] OpFree = 3'd2;
  localparam logic [2:0] OpInit = 3'd3;
  localparam logic [2:0] OpSettime = 3'd4;

  localparam logic [1:0] StUnused = 2'd0;
  localparam logic [1:0] StAlloc = 2'd1;
  localparam logic [1:0] StRun = 2'd2;

  typedef struct packed {
    logic [2:0] opcode;
    logic [4:0] slot;
    logic [31:0] delay;
    logic [7:0] tag;
    logic [1:0] dest_queue;
  } in_beat_t;

  typedef struct packed {
    logic kind;
    logic ok;
    logic [4:0] out_slot;
    logic [7:0] out_tag;
    logic [1:0] out_queue;
    logic switch_hit;
    logic last;
  } out_beat_t;
endpackage

[design/sdtq_in_if.sv]
// Valid/ready channel interfaces for input and result beats.
// Depends on sdtq_pkg.
`timescale 1ns / 1ps
interface sdtq_in_if;
  logic valid;
  logic ready;
  sdtq_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sdtq_out_if;
  logic valid;
  logic ready;
  sdtq_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/sorted_deadline_timer_queue.sv]
// Sorted deadline timer queue: one sequencer walks the linked deadline list.
// Depends on sdtq_pkg and the channel interfaces.
// Init, free of an idle slot and a tick with nothing due return to idle from decode; alloc scans slots.
// A tick expires up to 32 due timers with one expiry beat per cycle when the sink is
// ready; a settime that moves a running timer runs the unlink walk and then the insert walk.
// Throughput: one beat at a time. Reset is synchronous, active low, and clears the list at once.
`timescale 1ns / 1ps
module sorted_deadline_timer_queue (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [5:0] cfg_wdata,
  sdtq_in_if.sink    in_ch,
  sdtq_out_if.source out_ch
);
  import sdtq_pkg::*;

  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SDecode = 4'd1;
  localparam logic [3:0] SAlloc = 4'd2;
  localparam logic [3:0] SOutWait = 4'd3;
  localparam logic [3:0] SUnlink = 4'd4;
  localparam logic [3:0] SSetDl = 4'd5;
  localparam logic [3:0] SInsert = 4'd6;
  localparam logic [3:0] SExpire = 4'd7;
  localparam logic [3:0] SEarliest = 4'd8;

  logic [3:0] state_r;
  logic [1:0] status_r [NumTimers];
  logic [31:0] dl_r [NumTimers];
  logic [7:0] tag_r [NumTimers];
  logic [1:0] queue_r [NumTimers];
  logic [IdxW-1:0] link_r [NumTimers];
  logic [IdxW-1:0] head_r;
  logic [31:0] tick_r;
  logic [31:0] earliest_r;
  logic [5:0] tss_r;
  in_beat_t cmd_r;
  logic [IdxW-1:0] cur_r, prev_r;
  logic [IdxW:0] cnt_r;
  logic reinsert_r;
  logic out_valid_r;
  out_beat_t out_r;

  logic [IdxW-1:0] slot_ext, cur_follow, link_cur, link_slot;
  logic [31:0] tick_inc, dl_cur, dl_fol, dl_head;
  logic out_free, exp_hit, out_load;

  assign slot_ext = {1'b0, cmd_r.slot};
  assign link_cur = link_r[cur_r[4:0]];
  assign link_slot = link_r[cmd_r.slot];
  assign cur_follow = (cur_r >= SentIdx || link_cur > SentIdx) ? SentIdx : link_cur;
  assign dl_cur = (cur_r >= SentIdx) ? SentDeadline : dl_r[cur_r[4:0]];
  assign dl_fol = (cur_follow >= SentIdx) ? SentDeadline : dl_r[cur_follow[4:0]];
  assign dl_head = (head_r >= SentIdx) ? SentDeadline : dl_r[head_r[4:0]];
  assign tick_inc = tick_r + 32'd1;
  assign out_free = !out_valid_r || out_ch.ready;
  assign exp_hit = cur_r < SentIdx && cnt_r < (IdxW+1)'(MaxOut) && dl_cur <= tick_r;
  assign in_ch.ready = (state_r == SIdle);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_r;

  always_comb begin
    out_load = 1'b0;
    case (state_r)
      SAlloc: out_load = out_free && (status_r[cur_r[4:0]] == StUnused ||
                                      cur_r == IdxW'(NumTimers - 1));
      SExpire: out_load = out_free && exp_hit;
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SIdle;
      for (int i = 0; i < NumTimers; i++) status_r[i] <= StUnused;
      for (int i = 0; i < NumTimers; i++) link_r[i] <= NoLink;
      head_r <= SentIdx;
      tick_r <= '0;
      earliest_r <= SentDeadline;
      tss_r <= 6'd32;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) tss_r <= cfg_wdata;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        SIdle: begin
          if (in_ch.valid) begin
            cmd_r <= in_ch.data;
            state_r <= SDecode;
          end
          cur_r <= '0;
          cnt_r <= '0;
        end
        SDecode: begin
          cur_r <= (cmd_r.opcode == OpAlloc) ? '0 : head_r;
          prev_r <= NoLink;
          reinsert_r <= (cmd_r.opcode == OpSettime) && (status_r[cmd_r.slot] == StRun);
          case (cmd_r.opcode)
            OpTick: begin
              tick_r <= tick_inc;
              state_r <= (earliest_r > tick_inc) ? SIdle : SExpire;
            end
            OpAlloc: begin
              state_r <= SAlloc;
            end
            OpFree: begin
              if (status_r[cmd_r.slot] == StRun) begin
                state_r <= SUnlink;
              end else begin
                status_r[cmd_r.slot] <= StUnused;
                state_r <= SIdle;
              end
            end
            OpInit: begin
              tag_r[cmd_r.slot] <= cmd_r.tag;
              queue_r[cmd_r.slot] <= cmd_r.dest_queue;
              state_r <= SIdle;
            end
            OpSettime: begin
              if (status_r[cmd_r.slot] == StUnused) state_r <= SIdle;
              else if (status_r[cmd_r.slot] == StRun) state_r <= SUnlink;
              else state_r <= SSetDl;
            end
            default: state_r <= SIdle;
          endcase
        end
        SAlloc: begin
          if (out_free) begin
            if (status_r[cur_r[4:0]] == StUnused) begin
              status_r[cur_r[4:0]] <= StAlloc;
              link_r[cur_r[4:0]] <= NoLink;
              out_r <= '{kind: 1'b0, ok: 1'b1, out_slot: cur_r[4:0], out_tag: '0,
                         out_queue: '0, switch_hit: 1'b0, last: 1'b1};
              state_r <= SIdle;
            end else if (cur_r == IdxW'(NumTimers - 1)) begin
              out_r <= '{kind: 1'b0, ok: 1'b0, out_slot: '0, out_tag: '0,
                         out_queue: '0, switch_hit: 1'b0, last: 1'b1};
              state_r <= SIdle;
            end else begin
              cur_r <= cur_r + 1'b1;
            end
          end
        end
        SUnlink: begin
          if (head_r == slot_ext) begin
            head_r <= (link_slot > SentIdx) ? SentIdx : link_slot;
            link_r[cmd_r.slot] <= NoLink;
            state_r <= reinsert_r ? SSetDl : SEarliest;
          end else if (cur_r >= SentIdx || cnt_r > (IdxW+1)'(NumTimers)) begin
            link_r[cmd_r.slot] <= NoLink;
            state_r <= reinsert_r ? SSetDl : SEarliest;
          end else if (link_cur == slot_ext) begin
            link_r[cur_r[4:0]] <= (link_slot > SentIdx) ? SentIdx : link_slot;
            link_r[cmd_r.slot] <= NoLink;
            state_r <= reinsert_r ? SSetDl : SEarliest;
          end else begin
            cur_r <= cur_follow;
            cnt_r <= cnt_r + 1'b1;
          end
          if (!reinsert_r) status_r[cmd_r.slot] <= StUnused;
        end
        SSetDl: begin
          dl_r[cmd_r.slot] <= cmd_r.delay + tick_r;
          status_r[cmd_r.slot] <= StRun;
          cur_r <= head_r;
          prev_r <= NoLink;
          cnt_r <= '0;
          state_r <= SInsert;
        end
        SInsert: begin
          if (cur_r >= SentIdx || cnt_r > (IdxW+1)'(NumTimers) ||
              dl_r[cmd_r.slot] <= dl_cur) begin
            link_r[cmd_r.slot] <= (cur_r > SentIdx) ? SentIdx : cur_r;
            if (prev_r == NoLink) head_r <= slot_ext;
            else link_r[prev_r[4:0]] <= slot_ext;
            state_r <= SEarliest;
          end else begin
            prev_r <= cur_r;
            cur_r <= cur_follow;
            cnt_r <= cnt_r + 1'b1;
          end
        end
        SExpire: begin
          if (out_free) begin
            if (exp_hit) begin
              status_r[cur_r[4:0]] <= StAlloc;
              link_r[cur_r[4:0]] <= NoLink;
              out_r.kind <= 1'b1;
              out_r.ok <= 1'b0;
              out_r.out_slot <= cur_r[4:0];
              out_r.switch_hit <= (cur_r == tss_r);
              out_r.out_tag <= (cur_r == tss_r) ? 8'd0 : tag_r[cur_r[4:0]];
              out_r.out_queue <= (cur_r == tss_r) ? 2'd0 : queue_r[cur_r[4:0]];
              out_r.last <= !(cur_follow < SentIdx && cnt_r < (IdxW+1)'(MaxOut - 1) &&
                              dl_fol <= tick_r);
              cur_r <= cur_follow;
              cnt_r <= cnt_r + 1'b1;
            end else begin
              head_r <= cur_r;
              state_r <= SEarliest;
            end
          end
        end
        SEarliest: begin
          earliest_r <= dl_head;
          state_r <= SIdle;
        end
        default: state_r <= SIdle;
      endcase
    end
  end
endmodule

[bench/tb_sorted_deadline_timer_queue.sv]
// Testbench for the sorted deadline timer queue: directed table, then directed and random traffic per task slot.
// Depends on sdtq_pkg, the channel interfaces and the timer queue RTL.
`timescale 1ns / 1ps
module tb_sorted_deadline_timer_queue;
  import sdtq_pkg::*;

  typedef struct {
    in_beat_t beat;
    logic has_exp;
    out_beat_t exp;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [5:0] cfg_wdata = '0;
  sdtq_in_if in_ch();
  sdtq_out_if out_ch();

  sorted_deadline_timer_queue dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #2 clk = ~clk;

  logic [1:0] m_status [NumTimers];
  logic [31:0] m_deadline [NumTimers+1];
  logic [7:0] m_tag [NumTimers];
  logic [1:0] m_queue [NumTimers];
  logic [IdxW-1:0] m_link [NumTimers+1];
  logic [IdxW-1:0] m_head;
  logic [31:0] m_count;
  logic [31:0] m_earliest;
  logic [5:0] m_ts_slot;
  logic m_inited [NumTimers];

  out_beat_t pending_results[$];
  int mismatches = 0;
  int cycles = 0;
  logic stim_done = 1'b0;

  function automatic int next_of(int idx);
    return (m_link[idx] > SentIdx) ? NumTimers : int'(m_link[idx]);
  endfunction

  function automatic void model_reset();
    for (int i = 0; i < NumTimers; i++) begin
      m_status[i] = StUnused;
      m_deadline[i] = '0;
      m_tag[i] = '0;
      m_queue[i] = '0;
      m_link[i] = NoLink;
      m_inited[i] = 1'b0;
    end
    m_deadline[NumTimers] = SentDeadline;
    m_link[NumTimers] = NoLink;
    m_head = SentIdx;
    m_count = '0;
    m_earliest = SentDeadline;
    m_ts_slot = 6'd32;
  endfunction

  function automatic void unlink_timer(int s);
    int p;
    if (int'(m_head) == s) begin
      m_head = IdxW'(next_of(s));
    end else begin
      p = int'(m_head);
      for (int k = 0; k <= NumTimers && p < NumTimers; k++) begin
        if (int'(m_link[p]) == s) begin
          m_link[p] = IdxW'(next_of(s));
          break;
        end
        p = next_of(p);
      end
    end
    m_link[s] = NoLink;
    m_earliest = m_deadline[m_head];
  endfunction

  function automatic void link_sorted(int s);
    int prev;
    int t;
    prev = -1;
    t = int'(m_head);
    for (int k = 0; k <= NumTimers; k++) begin
      if (t >= NumTimers || m_deadline[s] <= m_deadline[t]) break;
      prev = t;
      t = next_of(t);
    end
    if (t > NumTimers) t = NumTimers;
    m_link[s] = IdxW'(t);
    if (prev < 0) m_head = IdxW'(s);
    else m_link[prev] = IdxW'(s);
    m_earliest = m_deadline[m_head];
  endfunction

  function automatic void predict_timer_results(in_beat_t b);
    out_beat_t r;
    int cur;
    int n;
    int s;
    int i;
    s = int'(b.slot);
    n = 0;
    case (b.opcode)
      OpTick: begin
        m_count = m_count + 1;
        if (m_earliest <= m_count) begin
          cur = int'(m_head);
          while (n < MaxOut && cur < NumTimers && m_deadline[cur] <= m_count) begin
            r = '0;
            r.kind = 1'b1;
            r.out_slot = cur[4:0];
            if (cur == int'(m_ts_slot)) begin
              r.switch_hit = 1'b1;
            end else begin
              r.out_tag = m_tag[cur];
              r.out_queue = m_queue[cur];
            end
            m_status[cur] = StAlloc;
            pending_results.push_back(r);
            n++;
            i = next_of(cur);
            m_link[cur] = NoLink;
            cur = i;
          end
          m_head = IdxW'(cur);
          m_earliest = m_deadline[m_head];
        end
      end
      OpAlloc: begin
        r = '0;
        for (i = 0; i < NumTimers; i++) begin
          if (m_status[i] == StUnused) break;
        end
        if (i < NumTimers) begin
          m_status[i] = StAlloc;
          m_link[i] = NoLink;
          r.ok = 1'b1;
          r.out_slot = i[4:0];
        end
        pending_results.push_back(r);
        n = 1;
      end
      OpFree: begin
        if (m_status[s] == StRun) unlink_timer(s);
        m_status[s] = StUnused;
      end
      OpInit: begin
        m_tag[s] = b.tag;
        m_queue[s] = b.dest_queue;
        m_inited[s] = 1'b1;
      end
      OpSettime: begin
        if (m_status[s] != StUnused) begin
          if (m_status[s] == StRun) unlink_timer(s);
          m_deadline[s] = b.delay + m_count;
          m_status[s] = StRun;
          link_sorted(s);
        end
      end
      default: ;
    endcase
    if (n > 0) pending_results[$].last = 1'b1;
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected beat %p", out_ch.data);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.data !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, out_ch.data);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stim_done && $urandom_range(0, 3) == 0) out_ch.ready <= 1'b1;
    else if ($urandom_range(0, 19) == 0) out_ch.ready <= 1'b0;
    else if ($urandom_range(0, 9) < 7) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 1) == 1);
  end

  task automatic send_beat(in_beat_t b);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk);
    in_ch.data <= b;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predict_timer_results(b);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_task_slot(logic [5:0] v);
    while (pending_results.size() != 0 || !in_ch.ready) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    m_ts_slot = v;
  endtask

  function automatic in_beat_t mk(logic [2:0] op, int s, logic [31:0] d, int t, int q);
    in_beat_t b;
    b.opcode = op;
    b.slot = s[4:0];
    b.delay = d;
    b.tag = t[7:0];
    b.dest_queue = q[1:0];
    return b;
  endfunction

  function automatic in_beat_t random_beat();
    int s;
    int pick;
    logic [31:0] d;
    in_beat_t b;
    s = $urandom_range(0, 7);
    if ($urandom_range(0, 9) == 0) s = $urandom_range(0, 31);
    pick = $urandom_range(0, 99);
    d = $urandom_range(0, 12);
    if ($urandom_range(0, 15) == 0) d = $urandom();
    b = mk(OpTick, s, d, $urandom_range(0, 255), $urandom_range(0, 3));
    if (pick < 40) b.opcode = OpTick;
    else if (pick < 52) b.opcode = OpAlloc;
    else if (pick < 60) b.opcode = OpFree;
    else if (pick < 75) b.opcode = OpInit;
    else if (pick < 97) b.opcode = OpSettime;
    else b.opcode = 3'($urandom_range(5, 7));
    if (b.opcode == OpSettime && !m_inited[s]) b.opcode = OpInit;
    return b;
  endfunction

  initial begin
    row_t rows[$];
    row_t r;
    in_beat_t b;
    int limit;
    model_reset();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    r.has_exp = 1'b1;
    r.exp = '0;
    r.exp.ok = 1'b1;
    r.exp.last = 1'b1;
    r.beat = mk(OpAlloc, 0, 0, 0, 0);
    rows.push_back(r);
    r.exp.out_slot = 5'd1;
    rows.push_back(r);
    r.has_exp = 1'b0;
    r.beat = mk(OpInit, 0, 0, 255, 3); rows.push_back(r);
    r.beat = mk(OpInit, 1, 0, 0, 0); rows.push_back(r);
    r.beat = mk(OpInit, 31, 0, 8'haa, 2); rows.push_back(r);
    r.beat = mk(OpSettime, 31, 5, 0, 0); rows.push_back(r);
    r.beat = mk(OpSettime, 0, 2, 0, 0); rows.push_back(r);
    r.beat = mk(OpSettime, 1, 1, 0, 0); rows.push_back(r);
    r.beat = mk(OpSettime, 1, 2, 0, 0); rows.push_back(r);
    r.beat = mk(OpTick, 0, 0, 0, 0); rows.push_back(r);
    r.beat = mk(OpTick, 0, 0, 0, 0); rows.push_back(r);
    r.beat = mk(OpSettime, 0, 32'hffffffff, 0, 0); rows.push_back(r);
    r.beat = mk(OpFree, 0, 0, 0, 0); rows.push_back(r);
    r.beat = mk(OpSettime, 0, 0, 0, 0); rows.push_back(r);
    r.beat = mk(3'd7, 31, 32'hffffffff, 255, 3); rows.push_back(r);
    r.beat = mk(3'd5, 0, 0, 0, 0); rows.push_back(r);
    r.beat = mk(OpTick, 31, 32'hffffffff, 255, 3); rows.push_back(r);

    foreach (rows[i]) begin
      int before_n;
      before_n = pending_results.size();
      send_beat(rows[i].beat);
      if (rows[i].has_exp && pending_results.size() > before_n &&
          pending_results[$] !== rows[i].exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Row %0d: table %p, predicted %p", i, rows[i].exp, pending_results[$]);
      end
    end

    write_task_slot(6'd1);
    send_beat(mk(OpAlloc, 0, 0, 0, 0));
    send_beat(mk(OpSettime, 1, 0, 0, 0));
    send_beat(mk(OpSettime, 1, 1, 0, 0));
    send_beat(mk(OpTick, 0, 0, 0, 0));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_task_slot(6'd0);
        1: write_task_slot(6'd63);
        2: write_task_slot(6'd3);
        default: write_task_slot(6'd32);
      endcase
      if (ph == 3) begin
        for (int k = 0; k < 34; k++) send_beat(mk(OpAlloc, 0, 0, 0, 0));
        for (int k = 0; k < 32; k++) send_beat(mk(OpInit, k, 0, k * 7, k));
        for (int k = 0; k < 32; k++) send_beat(mk(OpSettime, k, 32'd1, 0, 0));
        for (int k = 0; k < 2; k++) send_beat(mk(OpTick, 0, 0, 0, 0));
        send_beat(mk(OpSettime, 5, 32'hfffffff0, 0, 0));
        for (int k = 0; k < 32; k++) send_beat(mk(OpFree, k, 0, 0, 0));
      end
      limit = 0;
      while (limit < 8) begin
        b = random_beat();
        if (b.opcode <= OpSettime) limit++;
        send_beat(b);
      end
    end

    stim_done = 1'b1;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

[files.f]
design/sdtq_pkg.sv
design/sdtq_in_if.sv
design/sorted_deadline_timer_queue.sv
bench/tb_sorted_deadline_timer_queue.sv
